### design/ple_pkg.sv
// ----------------------------------------------------------------------------
// ple_pkg: shared types and constants of the positional list engine
// Sizes, request codes, the decoded command passed front to back, and the
// helpers that move values between the 32-bit ports and the entry width.
// ----------------------------------------------------------------------------
package ple_pkg;

  localparam int unsigned CAPACITY    = 16;
  localparam int unsigned VALUE_WIDTH = 32;

  localparam int unsigned REQ_W   = 3;
  localparam int unsigned POS_W   = 8;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned COUNT_W = 5;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned EXT_W = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT  = 3'd0,
    REQ_REMOVE  = 3'd1,
    REQ_READ    = 3'd2,
    REQ_REPLACE = 3'd3,
    REQ_CLEAR   = 3'd4
  } req_e;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_INSERT,
    OP_REMOVE,
    OP_READ,
    OP_REPLACE,
    OP_CLEAR
  } op_e;

  typedef logic [VALUE_WIDTH-1:0] entry_t;

  typedef struct packed {
    op_e              op;
    logic             pos_zero;
    logic [POS_W-1:0] position;
    logic [POS_W-1:0] index;
    entry_t           value;
  } cmd_t;

  function automatic entry_t to_entry(logic [DATA_W-1:0] v);
    logic [63:0] wide;
    wide = 64'(v);
    return wide[VALUE_WIDTH-1:0];
  endfunction

  function automatic logic [DATA_W-1:0] from_entry(entry_t e);
    logic [63:0] wide;
    wide = 64'(e);
    return wide[DATA_W-1:0];
  endfunction

endpackage

### design/ple_if.sv
// ----------------------------------------------------------------------------
// ple_req_if / ple_rsp_if: request and response channels
// Valid/ready channels; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------
interface ple_req_if;
  import ple_pkg::*;

  logic             valid;
  logic             ready;
  logic [REQ_W-1:0] req_type;
  logic [POS_W-1:0] position;
  logic [DATA_W-1:0] item_value;

  modport source (output valid, output req_type, output position, output item_value,
                  input ready);
  modport sink   (input valid, input req_type, input position, input item_value,
                  output ready);
endinterface

interface ple_rsp_if;
  import ple_pkg::*;

  logic               valid;
  logic               ready;
  logic               ok;
  logic [DATA_W-1:0]  read_value;
  logic [COUNT_W-1:0] item_count;

  modport source (output valid, output ok, output read_value, output item_count,
                  input ready);
  modport sink   (input valid, input ok, input read_value, input item_count,
                  output ready);
endinterface

### design/ple_front.sv
// ----------------------------------------------------------------------------
// ple_front: request intake and decode
// Registers each request, decodes its type and turns the 1-based position
// into a 0-based index for the cell array.
// ----------------------------------------------------------------------------
module ple_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  ple_req_if.sink       req_i,
  output logic          cmd_valid_o,
  input  logic          cmd_ready_i,
  output ple_pkg::cmd_t cmd_o
);
  import ple_pkg::*;

  logic vld_q, vld_d;
  cmd_t cmd_q, cmd_d;
  op_e  op;
  logic take;

  assign req_i.ready = !vld_q || cmd_ready_i;
  assign take        = req_i.valid && req_i.ready;

  always_comb begin
    unique case (req_i.req_type)
      REQ_INSERT:  op = OP_INSERT;
      REQ_REMOVE:  op = OP_REMOVE;
      REQ_READ:    op = OP_READ;
      REQ_REPLACE: op = OP_REPLACE;
      REQ_CLEAR:   op = OP_CLEAR;
      default:     op = OP_NOP;
    endcase
  end

  always_comb begin
    cmd_d = cmd_q;
    vld_d = vld_q;
    if (take) begin
      vld_d          = 1'b1;
      cmd_d.op       = op;
      cmd_d.pos_zero = (req_i.position == '0);
      cmd_d.position = req_i.position;
      cmd_d.index    = req_i.position - POS_W'(1);
      cmd_d.value    = to_entry(req_i.item_value);
    end else if (cmd_ready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

  assign cmd_valid_o = vld_q;
  assign cmd_o       = cmd_q;

endmodule

### design/ple_queue.sv
// ----------------------------------------------------------------------------
// ple_queue: command queue between front and back
// Small circular buffer of decoded commands so each side can stall alone.
// ----------------------------------------------------------------------------
module ple_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  ple_pkg::cmd_t push_cmd_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output ple_pkg::cmd_t pop_cmd_o
);
  import ple_pkg::*;

  cmd_t              slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] fill_q, fill_d;
  logic              push, pop;

  assign push_ready_o = (fill_q != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (fill_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_cmd_o    = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
    end
    case ({push, pop})
      2'b10:   fill_d = fill_q + QCNT_W'(1);
      2'b01:   fill_d = fill_q - QCNT_W'(1);
      default: fill_d = fill_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

### design/ple_back.sv
// ----------------------------------------------------------------------------
// ple_back: list cells and response register
// Checks each command against the current count, shifts the cell array on
// insert or remove, and registers the response.
// ----------------------------------------------------------------------------
module ple_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  output logic          cmd_ready_o,
  input  ple_pkg::cmd_t cmd_i,
  ple_rsp_if.source     rsp_o
);
  import ple_pkg::*;

  entry_t             entries_q [CAPACITY];
  logic [CNT_W-1:0]   count_q, count_d;
  logic               rsp_vld_q, rsp_vld_d;
  logic               ok_q, ok_d;
  logic [DATA_W-1:0]  rd_q, rd_d;
  logic [COUNT_W-1:0] cnt_out_q, cnt_out_d;

  logic             fire;
  logic [EXT_W-1:0] pos_ext, idx_ext, cnt_ext;
  logic             in_range, ins_range, ok;
  logic             do_ins, do_rem, do_rep;
  entry_t           picked;

  assign cmd_ready_o = !rsp_vld_q || rsp_o.ready;
  assign fire        = cmd_valid_i && cmd_ready_o;

  assign pos_ext   = EXT_W'(cmd_i.position);
  assign idx_ext   = EXT_W'(cmd_i.index);
  assign cnt_ext   = EXT_W'(count_q);
  assign in_range  = !cmd_i.pos_zero && (pos_ext <= cnt_ext);
  assign ins_range = !cmd_i.pos_zero && (pos_ext <= cnt_ext + EXT_W'(1))
                     && (cnt_ext < EXT_W'(CAPACITY));
  assign picked    = entries_q[cmd_i.index[IDX_W-1:0]];

  always_comb begin
    unique case (cmd_i.op)
      OP_INSERT:                      ok = ins_range;
      OP_REMOVE, OP_READ, OP_REPLACE: ok = in_range;
      OP_CLEAR:                       ok = 1'b1;
      default:                        ok = 1'b0;
    endcase
  end

  assign do_ins = fire && ok && (cmd_i.op == OP_INSERT);
  assign do_rem = fire && ok && (cmd_i.op == OP_REMOVE);
  assign do_rep = fire && ok && (cmd_i.op == OP_REPLACE);

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    localparam logic [EXT_W-1:0] Pos = EXT_W'(g);
    entry_t left, right, cell_d;
    logic   cell_we;

    if (g == 0) begin : g_first
      assign left = '0;
    end else begin : g_left
      assign left = entries_q[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right = '0;
    end else begin : g_right
      assign right = entries_q[g+1];
    end

    always_comb begin
      cell_d  = entries_q[g];
      cell_we = 1'b0;
      if (do_ins && Pos == idx_ext) begin
        cell_d  = cmd_i.value;
        cell_we = 1'b1;
      end else if (do_ins && Pos > idx_ext && Pos <= cnt_ext) begin
        cell_d  = left;
        cell_we = 1'b1;
      end else if (do_rem && Pos >= idx_ext && Pos + EXT_W'(1) < cnt_ext) begin
        cell_d  = right;
        cell_we = 1'b1;
      end else if (do_rep && Pos == idx_ext) begin
        cell_d  = cmd_i.value;
        cell_we = 1'b1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (cell_we) begin
        entries_q[g] <= cell_d;
      end
    end
  end

  always_comb begin
    count_d   = count_q;
    rsp_vld_d = rsp_vld_q;
    ok_d      = ok_q;
    rd_d      = rd_q;
    cnt_out_d = cnt_out_q;
    if (fire && ok) begin
      case (cmd_i.op)
        OP_INSERT: count_d = count_q + CNT_W'(1);
        OP_REMOVE: count_d = count_q - CNT_W'(1);
        OP_CLEAR:  count_d = '0;
        default:   count_d = count_q;
      endcase
    end
    if (fire) begin
      rsp_vld_d = 1'b1;
      ok_d      = ok;
      rd_d      = (ok && cmd_i.op == OP_READ) ? from_entry(picked) : '0;
      cnt_out_d = COUNT_W'(count_d);
    end else if (rsp_o.ready) begin
      rsp_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      rsp_vld_q <= 1'b0;
    end else begin
      count_q   <= count_d;
      rsp_vld_q <= rsp_vld_d;
    end
  end

  // hold the response payload until transferred
  always_ff @(posedge clk_i) begin
    ok_q      <= ok_d;
    rd_q      <= rd_d;
    cnt_out_q <= cnt_out_d;
  end

  assign rsp_o.valid      = rsp_vld_q;
  assign rsp_o.ok         = ok_q;
  assign rsp_o.read_value = rd_q;
  assign rsp_o.item_count = cnt_out_q;

endmodule

### design/positional_list_engine.sv
// ----------------------------------------------------------------------------
// positional_list_engine: ordered list with insert/remove at a position
// Front decodes requests, a two-entry queue decouples it from the back,
// which keeps the entries in a row of shifting cells.
// ----------------------------------------------------------------------------
//  channel | dir | payload                          | transfer
//  req_i   | in  | req_type, position, item_value   | valid && ready
//  rsp_o   | out | ok, read_value, item_count       | valid && ready
//
// Sustained rate is one request per cycle while rsp_o.ready stays high;
// every operation, including a full shift of the cell array, completes as
// the back end takes its command. A request passes the front register, then
// a queue slot, then the response register on its way to response valid.
// Reset clears the count and all valid flags; cell contents are left as is.
// A stalled response backs up into the queue and then the front.
module positional_list_engine (
  input logic       clk_i,
  input logic       rst_ni,
  ple_req_if.sink   req_i,
  ple_rsp_if.source rsp_o
);
  import ple_pkg::*;

  logic front_valid, front_ready;
  cmd_t front_cmd;
  logic back_valid, back_ready;
  cmd_t back_cmd;

  ple_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cmd_valid_o (front_valid),
    .cmd_ready_i (front_ready),
    .cmd_o       (front_cmd)
  );

  ple_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_cmd_i   (front_cmd),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready),
    .pop_cmd_o    (back_cmd)
  );

  ple_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (back_valid),
    .cmd_ready_o (back_ready),
    .cmd_i       (back_cmd),
    .rsp_o       (rsp_o)
  );

endmodule

### design/ple_checker.sv
// ----------------------------------------------------------------------------
// ple_checker: port-level checks for the positional list engine
// Watches both channels and flags responses that break the count limit, the
// read rule or the request/response balance, or that drop before transfer.
// ----------------------------------------------------------------------------
module ple_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        req_valid_i,
  input logic                        req_ready_i,
  input logic                        rsp_valid_i,
  input logic                        rsp_ready_i,
  input logic                        rsp_ok_i,
  input logic [ple_pkg::DATA_W-1:0]  rsp_read_value_i,
  input logic [ple_pkg::COUNT_W-1:0] rsp_item_count_i
);
  import ple_pkg::*;

  logic [2:0] pending_q, pending_d;
  logic       req_xfer, rsp_xfer;

  assign req_xfer = req_valid_i && req_ready_i;
  assign rsp_xfer = rsp_valid_i && rsp_ready_i;

  always_comb begin
    case ({req_xfer, rsp_xfer})
      2'b10:   pending_d = pending_q + 3'd1;
      2'b01:   pending_d = pending_q - 3'd1;
      default: pending_d = pending_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_d;
    end
  end

  a_count_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (32'(rsp_item_count_i) <= CAPACITY))
    else $error("item_count above capacity");

  a_read_needs_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && rsp_read_value_i != '0) |-> rsp_ok_i)
    else $error("non-zero read_value on failed request");

  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (pending_q != '0))
    else $error("response without an outstanding request");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_ready_i) |=> rsp_valid_i)
    else $error("response dropped before transfer");

endmodule

bind positional_list_engine ple_checker u_ple_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .req_valid_i      (req_i.valid),
  .req_ready_i      (req_i.ready),
  .rsp_valid_i      (rsp_o.valid),
  .rsp_ready_i      (rsp_o.ready),
  .rsp_ok_i         (rsp_o.ok),
  .rsp_read_value_i (rsp_o.read_value),
  .rsp_item_count_i (rsp_o.item_count)
);

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the positional list engine
// Drives list requests over the request channel and keeps its own copy of the
// list. Each response is checked field by field against the answer worked out
// when its request was transferred, under random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module tb_top;
  import ple_pkg::*;

  localparam int CLK_HALF      = 6;
  localparam int CLK_PERIOD    = 2 * CLK_HALF;
  localparam int TAIL_CYCLES   = 12;
  localparam int LIMIT_CYCLES  = 400000;
  localparam int RANDOM_ITEMS  = 1000;
  localparam int STEADY_ITEMS  = 120;

  // request codes the block does not know
  localparam logic [REQ_W-1:0] REQ_UNKNOWN_FIRST = 3'd5;
  localparam logic [REQ_W-1:0] REQ_UNKNOWN_LAST  = 3'd7;

  typedef struct packed {
    logic               ok;
    logic [DATA_W-1:0]  read_value;
    logic [COUNT_W-1:0] item_count;
  } list_answer_t;

  logic clk_i;
  logic rst_ni;

  ple_req_if req_if ();
  ple_rsp_if rsp_if ();

  positional_list_engine dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if.sink),
    .rsp_o  (rsp_if.source)
  );

  entry_t       list_vals[$];
  list_answer_t pending_answers[$];

  bit idle_on;
  int stall_left;
  int error_count;
  int kind_count[8];
  int rejected_count;
  int peak_len;

  always begin
    clk_i = 1'b1;
    #CLK_HALF;
    clk_i = 1'b0;
    #CLK_HALF;
  end

  // Work out the answer to one request and update the list copy.
  function automatic list_answer_t list_apply(logic [REQ_W-1:0] kind,
                                              logic [POS_W-1:0] pos,
                                              logic [DATA_W-1:0] val);
    list_answer_t ans;
    int unsigned  p;
    int unsigned  len;
    ans = '0;
    p   = pos;
    len = list_vals.size();
    case (kind)
      REQ_INSERT: begin
        if (p >= 1 && p <= len + 1 && len < CAPACITY) begin
          list_vals.insert(p - 1, entry_t'(val));
          ans.ok = 1'b1;
        end
      end
      REQ_REMOVE: begin
        if (p >= 1 && p <= len) begin
          list_vals.delete(p - 1);
          ans.ok = 1'b1;
        end
      end
      REQ_READ: begin
        if (p >= 1 && p <= len) begin
          ans.read_value = DATA_W'(list_vals[p - 1]);
          ans.ok = 1'b1;
        end
      end
      REQ_REPLACE: begin
        if (p >= 1 && p <= len) begin
          list_vals[p - 1] = entry_t'(val);
          ans.ok = 1'b1;
        end
      end
      REQ_CLEAR: begin
        list_vals.delete();
        ans.ok = 1'b1;
      end
      default: ;
    endcase
    ans.item_count = COUNT_W'(list_vals.size());
    return ans;
  endfunction

  task automatic send_request(input logic [REQ_W-1:0] kind,
                              input logic [POS_W-1:0] pos,
                              input logic [DATA_W-1:0] val);
    list_answer_t ans;
    if (idle_on && $urandom_range(3, 0) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.req_type   <= kind;
    req_if.position   <= pos;
    req_if.item_value <= val;
    do @(posedge clk_i); while (!req_if.ready);
    ans = list_apply(kind, pos, val);
    pending_answers.push_back(ans);
    kind_count[kind]++;
    if (!ans.ok) rejected_count++;
    if (list_vals.size() > peak_len) peak_len = list_vals.size();
  endtask

  // Hold the sender off until every outstanding response has come back.
  task automatic drain_answers();
    req_if.valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [REQ_W-1:0] pick_kind(bit growing);
    int r;
    r = $urandom_range(99, 0);
    if (r < 1) return REQ_CLEAR;
    if (r < 4) return logic'($urandom_range(REQ_UNKNOWN_LAST, REQ_UNKNOWN_FIRST)) ?
                      REQ_W'($urandom_range(REQ_UNKNOWN_LAST, REQ_UNKNOWN_FIRST)) :
                      REQ_UNKNOWN_FIRST;
    if (r < (growing ? 49 : 19)) return REQ_INSERT;
    if (r < 64) return REQ_REMOVE;
    if (r < 82) return REQ_READ;
    return REQ_REPLACE;
  endfunction

  // Mostly legal positions, with zero, past-the-end and wild ones mixed in.
  function automatic logic [POS_W-1:0] pick_position(logic [REQ_W-1:0] kind);
    int r;
    int len;
    r   = $urandom_range(99, 0);
    len = list_vals.size();
    if (r < 8)  return '0;
    if (r < 16) return POS_W'($urandom_range(255, len + 1));
    if (r < 22) return POS_W'($urandom);
    if (kind == REQ_INSERT) return POS_W'($urandom_range(len + 1, 1));
    return POS_W'($urandom_range((len > 0) ? len : 1, 1));
  endfunction

  task automatic test_directed_edges();
    send_request(REQ_CLEAR,   8'd1,   32'h1234_5678);
    send_request(REQ_READ,    8'd1,   '0);
    send_request(REQ_REMOVE,  8'd0,   '0);
    send_request(REQ_REPLACE, 8'd1,   32'hDEAD_BEEF);
    send_request(REQ_INSERT,  8'd0,   32'h1111_1111);
    send_request(REQ_INSERT,  8'd2,   32'h2222_2222);
    send_request(REQ_INSERT,  8'd1,   32'h0000_0000);
    send_request(REQ_INSERT,  8'd1,   32'hFFFF_FFFF);
    send_request(REQ_INSERT,  8'd3,   32'hA5A5_A5A5);
    send_request(REQ_INSERT,  8'd2,   32'h5A5A_5A5A);
    for (int p = 1; p <= 4; p++) send_request(REQ_READ, POS_W'(p), 32'hFFFF_FFFF);
    send_request(REQ_READ,    8'd5,   '0);
    send_request(REQ_READ,    8'd255, '0);
    send_request(REQ_REPLACE, 8'd4,   32'h8000_0000);
    send_request(REQ_READ,    8'd4,   '0);
    send_request(REQ_REMOVE,  8'd2,   '0);
    send_request(REQ_REMOVE,  8'd3,   '0);
    for (int k = REQ_UNKNOWN_FIRST; k <= REQ_UNKNOWN_LAST; k++)
      send_request(REQ_W'(k), 8'd1, 32'hFFFF_FFFF);
    send_request(REQ_READ,    8'd1,   '0);
  endtask

  task automatic test_full_list();
    send_request(REQ_CLEAR, 8'd0, '0);
    for (int i = 0; i < CAPACITY; i++)
      send_request(REQ_INSERT, POS_W'($urandom_range(i + 1, 1)), $urandom);
    send_request(REQ_INSERT,  POS_W'(CAPACITY + 1), $urandom);
    send_request(REQ_INSERT,  8'd1, $urandom);
    send_request(REQ_REPLACE, POS_W'(CAPACITY), $urandom);
    send_request(REQ_READ,    POS_W'(CAPACITY), '0);
    send_request(REQ_REMOVE,  POS_W'(CAPACITY), '0);
    send_request(REQ_REMOVE,  8'd1, '0);
    send_request(REQ_READ,    POS_W'(CAPACITY - 1), '0);
  endtask

  // Alternate growth and shrink phases so the count sweeps from empty to full.
  task automatic test_random_mix(input int items);
    logic [REQ_W-1:0] kind;
    bit               growing;
    growing = 1'b1;
    for (int i = 0; i < items; i++) begin
      if (i % 80 == 0) growing = !growing;
      kind = pick_kind(growing);
      send_request(kind, pick_position(kind), $urandom);
    end
  endtask

  task automatic test_drain_pause();
    test_random_mix(RANDOM_ITEMS / 2);
    drain_answers();
    test_random_mix(RANDOM_ITEMS / 2);
  endtask

  task automatic test_steady_stream();
    idle_on = 1'b0;
    test_random_mix(STEADY_ITEMS);
  endtask

  // Ready with random stall bursts while idle_on is set.
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      rsp_if.ready <= 1'b0;
    end else if (idle_on && $urandom_range(4, 0) == 0) begin
      stall_left = $urandom_range(3, 0);
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    list_answer_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (pending_answers.size() == 0) begin
        error_count++;
        $display("%0t: response with none outstanding: ok=%0b value=%h count=%0d",
                 $time, rsp_if.ok, rsp_if.read_value, rsp_if.item_count);
      end else begin
        want = pending_answers.pop_front();
        if (rsp_if.ok !== want.ok) begin
          error_count++;
          $display("%0t: ok mismatch: expected %0b, actual %0b",
                   $time, want.ok, rsp_if.ok);
        end
        if (rsp_if.read_value !== want.read_value) begin
          error_count++;
          $display("%0t: read_value mismatch: expected %h, actual %h",
                   $time, want.read_value, rsp_if.read_value);
        end
        if (rsp_if.item_count !== want.item_count) begin
          error_count++;
          $display("%0t: item_count mismatch: expected %0d, actual %0d",
                   $time, want.item_count, rsp_if.item_count);
        end
      end
    end
  end

  initial begin
    #(CLK_PERIOD * LIMIT_CYCLES);
    $display("Timed out with %0d responses outstanding", pending_answers.size());
    $display("** positional_list_engine: FAILED **");
    $finish;
  end

  initial begin
    idle_on        = 1'b1;
    stall_left     = 0;
    error_count    = 0;
    rejected_count = 0;
    peak_len       = 0;
    foreach (kind_count[k]) kind_count[k] = 0;
    rst_ni            <= 1'b0;
    req_if.valid      <= 1'b0;
    req_if.req_type   <= REQ_INSERT;
    req_if.position   <= '0;
    req_if.item_value <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_edges();
    test_full_list();
    test_drain_pause();
    test_steady_stream();

    drain_answers();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Requests: %0d insert, %0d remove, %0d read, %0d replace, %0d clear, %0d unknown",
             kind_count[REQ_INSERT], kind_count[REQ_REMOVE], kind_count[REQ_READ],
             kind_count[REQ_REPLACE], kind_count[REQ_CLEAR],
             kind_count[REQ_UNKNOWN_FIRST] + kind_count[REQ_UNKNOWN_FIRST + REQ_W'(1)]
             + kind_count[REQ_UNKNOWN_LAST]);
    $display("%0d requests rejected, list grew to %0d entries, %0d mismatches",
             rejected_count, peak_len, error_count);
    if (error_count == 0) begin
      $display("** positional_list_engine: PASSED **");
    end else begin
      $display("** positional_list_engine: FAILED **");
    end
    $finish;
  end

endmodule
